FILE: hw/rtl/sqi_pkg.sv
package sqi_pkg;

    // Longest run; the sample that reaches this count closes the run.
    localparam int MAX_SAMPLES = 65536;

    localparam int SMP_W      = 16;
    localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W      = SMP_W + CNT_W + 1;
    localparam int NUM_W      = SUM_W + 3;
    localparam int STEP_W     = 16;
    localparam int PROD_W     = NUM_W + STEP_W + 1;
    localparam int OUT_W      = 48;
    localparam int USED_W     = 17;
    localparam int STATUS_W   = 2;
    localparam int METHOD_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Divide-by-three long division, one byte per stage.
    localparam int DIG_W    = 8;
    localparam int N_DIG    = (PROD_W + DIG_W - 1) / DIG_W;
    localparam int X_W      = N_DIG * DIG_W;
    localparam int DIV3_REC = (2 ** (DIG_W + 3) + 2) / 3;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 1'd1;

    // Method codes; any code with the Simpson bit set selects Simpson
    localparam logic [METHOD_W-1:0] METH_RECT = 2'd0;
    localparam logic [METHOD_W-1:0] METH_TRAP = 2'd1;
    localparam logic [METHOD_W-1:0] METH_SIMP = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT = 2'd2;

    localparam logic signed [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [X_W-1:0] SAT_POS_MAG = (X_W'(1) << (OUT_W - 1)) - X_W'(1);
    localparam logic [X_W-1:0] SAT_NEG_MAG = X_W'(1) << (OUT_W - 1);

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    is_last;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] integral;
        logic [STATUS_W-1:0]     status;
        logic [USED_W-1:0]       samples_used;
    } t_out;

    // Everything the back end needs about one finished run
    typedef struct packed {
        logic signed [SMP_W-1:0] first;
        logic signed [SMP_W-1:0] prev;
        logic signed [SMP_W-1:0] last_smp;
        logic signed [SUM_W-1:0] odd_sum;
        logic signed [SUM_W-1:0] odd_prev;
        logic signed [SUM_W-1:0] even_sum;
        logic [CNT_W-1:0]        n;
    } t_run;

endpackage

FILE: hw/rtl/sqi_front.sv
module sqi_front import sqi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_acc,
    input  t_in  i_data,
    output logic o_push,
    output t_run o_run
);

    logic [CNT_W-1:0]        r_count;
    logic signed [SMP_W-1:0] r_first;
    logic signed [SMP_W-1:0] r_prev;
    logic signed [SUM_W-1:0] r_odd;
    logic signed [SUM_W-1:0] r_even;

    logic [CNT_W-1:0]        n_count;
    logic signed [SMP_W-1:0] n_first;
    logic signed [SUM_W-1:0] n_odd;
    logic signed [SUM_W-1:0] n_even;
    logic signed [SUM_W-1:0] s_ext;
    logic                    run_end;

    assign s_ext   = SUM_W'(i_data.sample);
    assign n_count = r_count + CNT_W'(1);
    assign n_first = (r_count == '0) ? i_data.sample : r_first;
    assign n_odd   = r_count[0] ? r_odd + s_ext : r_odd;
    assign n_even  = r_count[0] ? r_even : r_even + s_ext;
    assign run_end = i_data.is_last || (n_count == CNT_W'(MAX_SAMPLES));

    assign o_push = i_acc && run_end;

    always_comb begin
        o_run.first    = n_first;
        o_run.prev     = r_prev;
        o_run.last_smp = i_data.sample;
        o_run.odd_sum  = n_odd;
        o_run.odd_prev = r_odd;
        o_run.even_sum = n_even;
        o_run.n        = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_first <= '0;
            r_prev  <= '0;
            r_odd   <= '0;
            r_even  <= '0;
        end else if (i_acc) begin
            if (run_end) begin
                r_count <= '0;
                r_first <= '0;
                r_prev  <= '0;
                r_odd   <= '0;
                r_even  <= '0;
            end else begin
                r_count <= n_count;
                r_first <= n_first;
                r_prev  <= i_data.sample;
                r_odd   <= n_odd;
                r_even  <= n_even;
            end
        end
    end

endmodule

FILE: hw/rtl/sqi_fifo.sv
module sqi_fifo import sqi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_data,
    input  logic i_pop,
    output t_run o_data,
    output logic o_full,
    output logic o_empty
);

    t_run            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

endmodule

FILE: hw/rtl/sqi_back.sv
module sqi_back import sqi_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [METHOD_W-1:0] i_method,
    input  logic [STEP_W-1:0]   i_step,
    input  logic                i_q_valid,
    input  t_run                i_q_data,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out                o_out_data
);

    typedef enum logic [1:0] {DIV_1, DIV_2, DIV_6} t_div;

    typedef struct packed {
        logic [X_W-1:0]   x;
        logic [1:0]       rem;
        logic             neg;
        t_div             div;
        logic             few;
        logic [CNT_W-1:0] n;
    } t_dstg;

    // One long-division digit by three: returns {quotient digit, remainder}
    function automatic logic [DIG_W+1:0] div3_step(input logic [DIG_W+1:0] v);
        logic [2*DIG_W+3:0] p;
        logic [DIG_W-1:0]   q;
        logic [DIG_W+1:0]   t;
        p = (2*DIG_W+4)'(v) * (2*DIG_W+4)'(DIV3_REC);
        q = p[DIG_W+3 +: DIG_W];
        t = v - ((DIG_W+2)'(q) << 1) - (DIG_W+2)'(q);
        return {q, t[1:0]};
    endfunction

    logic adv;

    // stage A: weighted sum
    logic signed [NUM_W-1:0] a_odd, a_oddp, a_even, a_first, a_prev, a_s;
    logic signed [NUM_W-1:0] a_tot, a_pe, a_so, a_se, a_num;
    t_div                    a_div;
    logic                    a_few;
    logic                    r_a_v;
    logic signed [NUM_W-1:0] r_a_num;
    t_div                    r_a_div;
    logic                    r_a_few;
    logic [CNT_W-1:0]        r_a_n;

    // stage B: times h
    logic signed [PROD_W-1:0] b_prod;
    logic                     r_b_v;
    logic signed [PROD_W-1:0] r_b_prod;
    t_div                     r_b_div;
    logic                     r_b_few;
    logic [CNT_W-1:0]         r_b_n;

    // stage C and the divide chain
    logic                c_neg;
    logic [PROD_W-1:0]   c_abs;
    logic [PROD_W-1:0]   c_rnd;
    logic [PROD_W-1:0]   c_m;
    logic [PROD_W-1:0]   c_x;
    t_dstg               n_d  [N_DIG+1];
    t_dstg               r_d  [N_DIG+1];
    logic                r_dv [N_DIG+1];
    logic [DIG_W+1:0]    d_v  [N_DIG];
    logic [DIG_W+1:0]    d_qr [N_DIG];

    // output register
    logic     f_sat;
    t_out     n_out;
    logic     r_ov;
    t_out     r_out;

    assign adv   = !r_ov || !i_out_stall;
    assign o_pop = i_q_valid && adv;

    assign a_odd   = NUM_W'(i_q_data.odd_sum);
    assign a_oddp  = NUM_W'(i_q_data.odd_prev);
    assign a_even  = NUM_W'(i_q_data.even_sum);
    assign a_first = NUM_W'(i_q_data.first);
    assign a_prev  = NUM_W'(i_q_data.prev);
    assign a_s     = NUM_W'(i_q_data.last_smp);

    always_comb begin
        a_tot = a_odd + a_even;
        a_pe  = a_prev + a_s;
        // odd count: 2 * (4 odd + 2 even - f0 - f[n-1]), weights folded
        a_so  = ((a_odd <<< 2) + (a_even <<< 1) - a_first - a_s) <<< 1;
        // even count: Simpson to n-2, then 3 * (f[n-2] + f[n-1]) over 6
        a_se  = (((a_oddp <<< 2) + (a_even <<< 1) - a_first - a_prev) <<< 1)
              + (a_pe <<< 1) + a_pe;
        a_num = a_tot - a_s;
        a_div = DIV_1;
        a_few = 1'b0;
        if (|(i_method & METH_SIMP)) begin
            if (i_q_data.n < CNT_W'(3)) begin
                a_num = '0;
                a_few = 1'b1;
            end else if (i_q_data.n[0]) begin
                a_num = a_so;
                a_div = DIV_6;
            end else begin
                a_num = a_se;
                a_div = DIV_6;
            end
        end else if (i_method == METH_TRAP) begin
            a_num = (a_tot <<< 1) - a_first - a_s;
            a_div = DIV_2;
        end
    end

    assign b_prod = PROD_W'(r_a_num) * PROD_W'(signed'({1'b0, i_step}));

    always_comb begin
        c_neg = r_b_prod[PROD_W-1];
        c_abs = c_neg ? PROD_W'(-r_b_prod) : PROD_W'(r_b_prod);
        case (r_b_div)
            DIV_6:   c_rnd = PROD_W'(3);
            DIV_2:   c_rnd = PROD_W'(1);
            default: c_rnd = '0;
        endcase
        c_m = c_abs + c_rnd;
        c_x = (r_b_div == DIV_1) ? c_m : (c_m >> 1);
    end

    // Most significant byte first; quotient bytes replace dividend bytes
    always_comb begin
        n_d[0].x   = X_W'(c_x);
        n_d[0].rem = '0;
        n_d[0].neg = c_neg;
        n_d[0].div = r_b_div;
        n_d[0].few = r_b_few;
        n_d[0].n   = r_b_n;
        for (int k = 0; k < N_DIG; k++) begin
            n_d[k+1] = r_d[k];
            d_v[k]   = {r_d[k].rem, r_d[k].x[(N_DIG-1-k)*DIG_W +: DIG_W]};
            d_qr[k]  = div3_step(d_v[k]);
            if (r_d[k].div == DIV_6) begin
                n_d[k+1].x[(N_DIG-1-k)*DIG_W +: DIG_W] = d_qr[k][DIG_W+1:2];
                n_d[k+1].rem = d_qr[k][1:0];
            end
        end
    end

    always_comb begin
        f_sat = r_d[N_DIG].neg ? (r_d[N_DIG].x > SAT_NEG_MAG)
                               : (r_d[N_DIG].x > SAT_POS_MAG);
        n_out.samples_used = USED_W'(r_d[N_DIG].n);
        if (r_d[N_DIG].few) begin
            n_out.integral = '0;
            n_out.status   = ST_FEW;
        end else if (f_sat) begin
            n_out.integral = r_d[N_DIG].neg ? SAT_NEG : SAT_POS;
            n_out.status   = ST_SAT;
        end else begin
            n_out.integral = r_d[N_DIG].neg ? -r_d[N_DIG].x[OUT_W-1:0]
                                            : r_d[N_DIG].x[OUT_W-1:0];
            n_out.status   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_ov  <= 1'b0;
            for (int k = 0; k <= N_DIG; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (adv) begin
            r_a_v   <= i_q_valid;
            r_b_v   <= r_a_v;
            r_dv[0] <= r_b_v;
            for (int k = 0; k < N_DIG; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
            r_ov <= r_dv[N_DIG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_num  <= a_num;
            r_a_div  <= a_div;
            r_a_few  <= a_few;
            r_a_n    <= i_q_data.n;
            r_b_prod <= b_prod;
            r_b_div  <= r_a_div;
            r_b_few  <= r_a_few;
            r_b_n    <= r_a_n;
            for (int k = 0; k <= N_DIG; k++) begin
                r_d[k] <= n_d[k];
            end
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/sampled_quadrature_integrator_top.sv
// Path: after a run's last sample beat is taken, its result passes the queue write, weighted sum,
// multiply by h, round, 7 divide-by-three stages and the output register; an output stall holds it.
// Throughput: 1 sample beat per cycle, queue not full; 1 result per cycle unless stalled; back end fully pipelined.
// Reset: synchronous, active low; clears run state, queue, pipeline valids and both registers.
module sampled_quadrature_integrator_top import sqi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // sample beats
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data
);

    logic [METHOD_W-1:0] r_method;
    logic [STEP_W-1:0]   r_step;

    logic in_acc;
    logic q_push;
    t_run q_wdata;
    t_run q_rdata;
    logic q_pop;
    logic q_full;
    logic q_empty;

    // Front end only stalls when the run queue is full; the back end's
    // output stall never reaches the sample port directly.
    assign o_in_stall = q_full;
    assign in_acc     = i_in_valid && !q_full;

    // The back end reads the method at stage A and the step at stage B; they must only be rewritten
    // with the block idle (the block does not enforce this), so every run sees one setting.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= METH_RECT;
            r_step   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_METHOD: r_method <= i_cfg_data[METHOD_W-1:0];
                CFG_STEP:   r_step   <= i_cfg_data[STEP_W-1:0];
            endcase
        end
    end

    // Front: counts the run, keeps first/previous sample and the odd/even
    // index sums; pushes one record when a run closes.
    sqi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_data  (i_in_data),
        .o_push  (q_push),
        .o_run   (q_wdata)
    );

    // Short queue of finished runs between front and back
    sqi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: weights, scales by h, rounds half away from zero, saturates
    sqi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_method    (r_method),
        .i_step      (r_step),
        .i_q_valid   (!q_empty),
        .i_q_data    (q_rdata),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_SAT) |->
        (o_out_data.integral == SAT_POS || o_out_data.integral == SAT_NEG))
        else $error("saturated result not at a bound");

    a_few_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_FEW) |->
        (o_out_data.integral == '0 &&
         (o_out_data.samples_used == USED_W'(1) || o_out_data.samples_used == USED_W'(2))))
        else $error("too-few status on a long run or non-zero value");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_full && !q_pop) |=> !q_empty)
        else $error("run queue lost an entry");
`endif

endmodule
